// ===== hdl/vscpp_pkg.sv =====
// ----------------------------------------------------------------------------
// vscpp_pkg
// Shared types, constants and the quarter-sine gain table of the panner.
// ----------------------------------------------------------------------------
package vscpp_pkg;

  localparam int VOICE_COUNT = 8;
  localparam int SINE_N      = 256;
  localparam int SAMPLE_BITS = 24;
  localparam int VB          = $clog2(VOICE_COUNT);
  localparam int IDXB        = $clog2(SINE_N + 1);

  localparam logic [14:0] GAIN_RESET  = 15'd23170;
  localparam logic [14:0] RANGE_RESET = 15'd26214;
  localparam logic [15:0] WIDTH_RESET = 16'd32768;
  localparam logic [15:0] COEFF_RESET = 16'd3277;
  localparam logic [15:0] Q15_ONE     = 16'd32768;

  // Ceiling reciprocals of the series divisors (2j)(2j+1). With a shift of 42 the
  // product gives the exact floor quotient for any dividend below 2^32.
  localparam int              RCP_SHIFT = 42;
  localparam longint unsigned RCP_ONE   = 64'd1 << RCP_SHIFT;
  typedef longint unsigned rcp_tab_t [1:12];
  localparam rcp_tab_t TAYLOR_RCP = '{
    (RCP_ONE + 64'd5) / 64'd6,     (RCP_ONE + 64'd19) / 64'd20,
    (RCP_ONE + 64'd41) / 64'd42,   (RCP_ONE + 64'd71) / 64'd72,
    (RCP_ONE + 64'd109) / 64'd110, (RCP_ONE + 64'd155) / 64'd156,
    (RCP_ONE + 64'd209) / 64'd210, (RCP_ONE + 64'd271) / 64'd272,
    (RCP_ONE + 64'd341) / 64'd342, (RCP_ONE + 64'd419) / 64'd420,
    (RCP_ONE + 64'd505) / 64'd506, (RCP_ONE + 64'd599) / 64'd600
  };

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_BLOCK  = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_RANGE = 2'd0,
    CFG_WIDTH = 2'd1,
    CFG_COEFF = 2'd2,
    CFG_SPARE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_UPDATE,
    OP_BLOCK,
    OP_SAMPLE
  } op_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_RANK,
    BK_RMUL,
    BK_RLOAD,
    BK_RDIV,
    BK_RWR,
    BK_SMOOTH,
    BK_SWR,
    BK_SGAIN,
    BK_SMUL,
    BK_SACC,
    BK_EMIT
  } bk_state_e;

  typedef struct packed {
    op_e                          op;
    logic [VB-1:0]                voice;
    logic                         voice_ok;
    logic                         active;
    logic [6:0]                   note;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                         frame_end;
  } item_t;

  typedef struct packed {
    logic [14:0] range_limit;
    logic [15:0] width_scale;
    logic [15:0] smooth_coeff;
  } cfg_t;

  typedef logic [14:0] sine_tab_t [0:SINE_N];

  // Taylor series of sin in Q30, evaluated at elaboration.
  function automatic sine_tab_t build_sine();
    sine_tab_t         tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    longint unsigned   g;
    logic [127:0]      wide;
    for (int k = 0; k <= SINE_N; k++) begin
      x    = (64'd1686629713 * longint'(k)) / SINE_N;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int j = 1; j <= 12; j++) begin
        wide = 128'((term * x2) >> 30) * 128'(TAYLOR_RCP[j]);
        term = 64'(wide >> RCP_SHIFT);
        if ((j % 2) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      g = (longint'(sum) * 64'd32767 + 64'd536870912) >> 30;
      if (g > 64'd32767) g = 64'd32767;
      tab[k] = g[14:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// ===== hdl/vscpp_front.sv =====
// ----------------------------------------------------------------------------
// vscpp_front
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module vscpp_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        command_i,
  input  logic [vscpp_pkg::VB-1:0]          voice_i,
  input  logic                              active_i,
  input  logic [6:0]                        note_i,
  input  logic signed [vscpp_pkg::SAMPLE_BITS-1:0] voice_sample_i,
  input  logic                              frame_end_i,
  output vscpp_pkg::item_t                  head_o,
  output logic                              head_valid_o,
  input  logic                              head_pop_i
);
  import vscpp_pkg::*;

  item_t      fifo_q [0:1];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  item_t      cls;
  logic       wr_en;
  logic       rd_en;

  always_comb begin
    cls.voice     = voice_i;
    cls.voice_ok  = (int'(voice_i) < VOICE_COUNT);
    cls.active    = active_i;
    cls.note      = note_i;
    cls.sample    = voice_sample_i;
    cls.frame_end = frame_end_i;
    unique case (cmd_e'(command_i))
      CMD_UPDATE: cls.op = cls.voice_ok ? OP_UPDATE : OP_NONE;
      CMD_BLOCK:  cls.op = OP_BLOCK;
      CMD_SAMPLE: cls.op = OP_SAMPLE;
      default:    cls.op = OP_NONE;
    endcase
  end

  assign full         = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = fifo_q[rd_ptr_q];
  assign wr_en        = push && !full && (cls.op != OP_NONE);
  assign rd_en        = head_pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) fifo_q[wr_ptr_q] <= cls;
  end

endmodule

// ===== hdl/vscpp_back.sv =====
// ----------------------------------------------------------------------------
// vscpp_back
// Executes queued items: ranking, pan smoothing, mixing and result output.
// ----------------------------------------------------------------------------
module vscpp_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  vscpp_pkg::cfg_t         cfg_i,
  input  vscpp_pkg::item_t        head_i,
  input  logic                    head_valid_i,
  output logic                    head_pop_o,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [vscpp_pkg::SAMPLE_BITS-1:0] left_mix_o,
  output logic signed [vscpp_pkg::SAMPLE_BITS-1:0] right_mix_o
);
  import vscpp_pkg::*;

  localparam int DIVW = 20;
  localparam int NUMW = 31 + VB;
  localparam logic [VB-1:0] LAST_VOICE = VB'(VOICE_COUNT - 1);
  localparam logic [4:0] DIV_LAST = 5'(DIVW - 1);
  localparam longint SAT_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -(64'sd1 <<< (SAMPLE_BITS - 1));

  bk_state_e state_q, state_d;
  item_t     item_q;
  logic [VB-1:0] vidx_q;

  logic              act_q   [VOICE_COUNT];
  logic [6:0]        note_q  [VOICE_COUNT];
  logic signed [15:0] tgt_q  [VOICE_COUNT];
  logic signed [15:0] cur_q  [VOICE_COUNT];
  logic [14:0]       gl_q    [VOICE_COUNT];
  logic [14:0]       gr_q    [VOICE_COUNT];
  logic [47:0]       acc_l_q, acc_r_q;

  logic [32:0]       prod_q;
  logic [NUMW-1:0]   num_q;
  logic [VB-1:0]     absoff_q;
  logic              neg_q;
  logic [VB-1:0]     d_q;
  logic [DIVW-1:0]   dvd_q;
  logic [DIVW-1:0]   quo_q;
  logic [VB-1:0]     rem_q;
  logic [4:0]        cnt_q;
  logic signed [39:0] pl_q, pr_q;
  logic              out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_l_q, out_r_q;

  // Combinational helpers.
  logic [VB:0]       n_act;
  logic [VB:0]       rank;
  logic [VB-1:0]     d_c;
  logic signed [VB+2:0] off;
  logic [VB+2:0]     absoff_w;
  logic [15:0]       wsat;
  logic [15:0]       csat;
  logic signed [16:0] diff;
  logic [16:0]       dmag;
  logic [18:0]       step;
  logic signed [19:0] newcur;
  logic [15:0]       ucur;
  logic [31:0]       idx_w;
  logic [IDXB-1:0]   idx;
  logic [VB:0]       rtrial;
  logic [DIVW-1:0]   mag_c;
  logic last_voice;

  function automatic logic signed [SAMPLE_BITS-1:0] mix_out(input logic [47:0] acc);
    logic signed [48:0] v;
    logic signed [48:0] q;
    v = $signed({acc[47], acc}) + 49'sd16384;
    q = v >>> 15;
    if (q > 49'(SAT_HI)) q = 49'(SAT_HI);
    if (q < 49'(SAT_LO)) q = 49'(SAT_LO);
    return q[SAMPLE_BITS-1:0];
  endfunction

  always_comb begin
    n_act = '0;
    rank  = '0;
    for (int u = 0; u < VOICE_COUNT; u++) begin
      n_act = n_act + {{VB{1'b0}}, act_q[u]};
      if (act_q[u] && ((note_q[u] < note_q[vidx_q]) ||
          ((note_q[u] == note_q[vidx_q]) && (u < int'(vidx_q))))) begin
        rank = rank + 1'b1;
      end
    end
    d_c      = VB'(n_act - 1'b1);
    off      = $signed({2'b00, rank[VB-1:0], 1'b0}) - $signed({3'b000, d_c});
    absoff_w = off[VB+2] ? (VB+3)'(-off) : (VB+3)'(off);
    wsat     = (cfg_i.width_scale > Q15_ONE) ? Q15_ONE : cfg_i.width_scale;
    csat     = (cfg_i.smooth_coeff > Q15_ONE) ? Q15_ONE : cfg_i.smooth_coeff;
    diff     = 17'(tgt_q[vidx_q]) - 17'(cur_q[vidx_q]);
    dmag     = diff[16] ? 17'(-diff) : 17'(diff);
    step     = 19'((34'(prod_q) + 34'd16384) >> 15);
    newcur   = neg_q ? (20'(cur_q[vidx_q]) - $signed({1'b0, step}))
                     : (20'(cur_q[vidx_q]) + $signed({1'b0, step}));
    ucur     = {~cur_q[vidx_q][15], cur_q[vidx_q][14:0]};
    idx_w    = (32'(ucur) * 32'(SINE_N)) >> 16;
    idx      = (idx_w > 32'(SINE_N)) ? IDXB'(SINE_N) : idx_w[IDXB-1:0];
    rtrial   = {rem_q, dvd_q[DIVW-1]};
    mag_c    = quo_q;
    last_voice = (vidx_q == LAST_VOICE);
  end

  assign head_pop_o  = (state_q == BK_IDLE) && head_valid_i;
  assign empty       = !out_valid_q;
  assign left_mix_o  = out_l_q;
  assign right_mix_o = out_r_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (head_valid_i) begin
          unique case (head_i.op)
            OP_UPDATE: state_d = BK_RANK;
            OP_BLOCK:  state_d = BK_SMOOTH;
            OP_SAMPLE: state_d = BK_SMUL;
            default:   state_d = BK_IDLE;
          endcase
        end
      end
      BK_RANK: begin
        if (n_act == '0) state_d = BK_IDLE;
        else if (!act_q[vidx_q] || n_act == (VB+1)'(1)) begin
          state_d = last_voice ? BK_IDLE : BK_RANK;
        end else state_d = BK_RMUL;
      end
      BK_RMUL:  state_d = BK_RLOAD;
      BK_RLOAD: state_d = BK_RDIV;
      BK_RDIV:  state_d = (cnt_q == DIV_LAST) ? BK_RWR : BK_RDIV;
      BK_RWR:   state_d = last_voice ? BK_IDLE : BK_RANK;
      BK_SMOOTH: begin
        if (act_q[vidx_q]) state_d = BK_SWR;
        else state_d = last_voice ? BK_IDLE : BK_SMOOTH;
      end
      BK_SWR:   state_d = BK_SGAIN;
      BK_SGAIN: state_d = last_voice ? BK_IDLE : BK_SMOOTH;
      BK_SMUL:  state_d = BK_SACC;
      BK_SACC:  state_d = item_q.frame_end ? BK_EMIT : BK_IDLE;
      BK_EMIT:  state_d = (!out_valid_q || pop) ? BK_IDLE : BK_EMIT;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      vidx_q      <= '0;
      out_valid_q <= 1'b0;
      acc_l_q     <= '0;
      acc_r_q     <= '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        act_q[v]  <= 1'b0;
        note_q[v] <= '0;
        tgt_q[v]  <= '0;
        cur_q[v]  <= '0;
        gl_q[v]   <= GAIN_RESET;
        gr_q[v]   <= GAIN_RESET;
      end
    end else begin
      state_q <= state_d;
      // While a new result waits to be loaded, a pop is handled in the emit state.
      if (pop && out_valid_q && (state_q != BK_EMIT)) out_valid_q <= 1'b0;
      unique case (state_q)
        BK_IDLE: begin
          vidx_q <= '0;
          if (head_valid_i && head_i.op == OP_UPDATE) begin
            act_q[head_i.voice]  <= head_i.active;
            note_q[head_i.voice] <= head_i.note;
          end
        end
        BK_RANK: begin
          if (n_act != '0 && act_q[vidx_q] && n_act == (VB+1)'(1)) begin
            tgt_q[vidx_q] <= '0;
          end
          if (state_d == BK_RANK) vidx_q <= vidx_q + 1'b1;
        end
        BK_RWR: begin
          if (mag_c > DIVW'(32767)) tgt_q[vidx_q] <= neg_q ? -16'sd32767 : 16'sd32767;
          else tgt_q[vidx_q] <= neg_q ? -$signed(mag_c[15:0]) : $signed(mag_c[15:0]);
          if (!last_voice) vidx_q <= vidx_q + 1'b1;
        end
        BK_SMOOTH: begin
          if (!act_q[vidx_q] && !last_voice) vidx_q <= vidx_q + 1'b1;
        end
        BK_SWR: begin
          if (newcur > 20'sd32767) cur_q[vidx_q] <= 16'sd32767;
          else if (newcur < -20'sd32768) cur_q[vidx_q] <= -16'sd32768;
          else cur_q[vidx_q] <= newcur[15:0];
        end
        BK_SGAIN: begin
          gr_q[vidx_q] <= SINE_TAB[idx];
          gl_q[vidx_q] <= SINE_TAB[IDXB'(SINE_N) - idx];
          if (!last_voice) vidx_q <= vidx_q + 1'b1;
        end
        BK_SACC: begin
          acc_l_q <= acc_l_q + 48'($signed(pl_q));
          acc_r_q <= acc_r_q + 48'($signed(pr_q));
        end
        BK_EMIT: begin
          if (!out_valid_q || pop) begin
            out_valid_q <= 1'b1;
            acc_l_q     <= '0;
            acc_r_q     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (head_pop_o) item_q <= head_i;
    unique case (state_q)
      BK_RANK: begin
        prod_q   <= 33'(cfg_i.range_limit) * 33'(wsat);
        absoff_q <= absoff_w[VB-1:0];
        neg_q    <= off[VB+2];
        d_q      <= d_c;
      end
      BK_RMUL: num_q <= NUMW'(prod_q[30:0]) * NUMW'(absoff_q);
      BK_RLOAD: begin
        dvd_q <= DIVW'((NUMW'(num_q) + (NUMW'(d_q) << 14)) >> 15);
        rem_q <= '0;
        quo_q <= '0;
        cnt_q <= '0;
      end
      BK_RDIV: begin
        // Restoring division by the spread count, one quotient bit a cycle.
        if (rtrial >= {1'b0, d_q}) begin
          rem_q <= VB'(rtrial - {1'b0, d_q});
          quo_q <= {quo_q[DIVW-2:0], 1'b1};
        end else begin
          rem_q <= rtrial[VB-1:0];
          quo_q <= {quo_q[DIVW-2:0], 1'b0};
        end
        dvd_q <= {dvd_q[DIVW-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
      end
      BK_SMOOTH: begin
        prod_q <= 33'(csat) * 33'(dmag);
        neg_q  <= diff[16];
      end
      BK_SMUL: begin
        if (item_q.voice_ok && act_q[item_q.voice]) begin
          pl_q <= item_q.sample * $signed({1'b0, gl_q[item_q.voice]});
          pr_q <= item_q.sample * $signed({1'b0, gr_q[item_q.voice]});
        end else begin
          pl_q <= '0;
          pr_q <= '0;
        end
      end
      BK_EMIT: begin
        if (!out_valid_q || pop) begin
          out_l_q <= mix_out(acc_l_q);
          out_r_q <= mix_out(acc_r_q);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/voice_spread_constant_power_panner.sv =====
// ----------------------------------------------------------------------------
// voice_spread_constant_power_panner
// Constant-power stereo panner and mixer for eight voices.
// ----------------------------------------------------------------------------
// A sample item is weighted by its voice's gains, then added to the mix; a frame-end item then
// emits the mix. A block start leaves the queue, then smooths each active voice's pan and gains.
// A voice update ranks the voices and, when two or more are active, spreads their pans
// through the one-bit-a-cycle divider; a two-entry queue absorbs bursts.
// Reset loads the register defaults and clears control state, but not the datapath registers.
module voice_spread_constant_power_panner (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic [1:0]                    command_i,
  input  logic [2:0]                    voice_i,
  input  logic                          active_i,
  input  logic [6:0]                    note_i,
  input  logic signed [23:0]            voice_sample_i,
  input  logic                          frame_end_i,
  output logic signed [23:0]            left_mix_o,
  output logic signed [23:0]            right_mix_o
);
  import vscpp_pkg::*;

  cfg_t  cfg_q;
  item_t head;
  logic  head_valid;
  logic  head_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_limit  <= RANGE_RESET;
      cfg_q.width_scale  <= WIDTH_RESET;
      cfg_q.smooth_coeff <= COEFF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RANGE: cfg_q.range_limit  <= cfg_data_i[14:0];
        CFG_WIDTH: cfg_q.width_scale  <= cfg_data_i;
        CFG_COEFF: cfg_q.smooth_coeff <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vscpp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .voice_i        (voice_i),
    .active_i       (active_i),
    .note_i         (note_i),
    .voice_sample_i (voice_sample_i),
    .frame_end_i    (frame_end_i),
    .head_o         (head),
    .head_valid_o   (head_valid),
    .head_pop_i     (head_pop)
  );

  vscpp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_pop_o   (head_pop),
    .empty        (empty),
    .pop          (pop),
    .left_mix_o   (left_mix_o),
    .right_mix_o  (right_mix_o)
  );

endmodule
